### rtl/cpet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpet_pkg;

  localparam int unsigned MaxPairsDef  = 32;
  localparam int unsigned MaxBodiesDef = 255;

  localparam int unsigned OpW     = 2;
  localparam int unsigned HandleW = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned KeyW    = 2 * HandleW;

  localparam logic [OpW-1:0] OP_CONTACT   = 2'd0;
  localparam logic [OpW-1:0] OP_FRAME_END = 2'd1;
  localparam logic [OpW-1:0] OP_DESTROY   = 2'd2;

  localparam logic [KindW-1:0] KIND_BEGIN        = 3'd0;
  localparam logic [KindW-1:0] KIND_STAY         = 3'd1;
  localparam logic [KindW-1:0] KIND_END          = 3'd2;
  localparam logic [KindW-1:0] KIND_FRAME_DONE   = 3'd3;
  localparam logic [KindW-1:0] KIND_DESTROY_DONE = 3'd4;
  localparam logic [KindW-1:0] KIND_FULL         = 3'd5;

  localparam logic [HandleW-1:0] HandleNone = 8'hFF;

  typedef struct packed {
    logic capture;
    logic contact_wr;
    logic destroy_wr;
    logic pend_init;
    logic scan_start;
    logic scan_step;
    logic emit_end;
    logic emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           contact_ok;
    logic           out_free;
    logic           scan_last;
    logic           found;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/cpet_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cpet_in_if;
  logic                            valid;
  logic                            ready;
  logic [cpet_pkg::OpW-1:0]        operation;
  logic [cpet_pkg::HandleW-1:0]    first_body;
  logic [cpet_pkg::HandleW-1:0]    second_body;

  modport source (output valid, output operation, output first_body, output second_body,
                  input ready);
  modport sink   (input valid, input operation, input first_body, input second_body,
                  output ready);
endinterface

interface cpet_out_if;
  logic                            valid;
  logic                            ready;
  logic [cpet_pkg::KindW-1:0]      event_kind;
  logic [cpet_pkg::HandleW-1:0]    event_first;
  logic [cpet_pkg::HandleW-1:0]    event_second;
  logic                            last;

  modport source (output valid, output event_kind, output event_first, output event_second,
                  output last, input ready);
  modport sink   (input valid, input event_kind, input event_first, input event_second,
                  input last, output ready);
endinterface

`default_nettype wire

### rtl/contact_pair_event_tracker_unit.sv
// Contact and destroy: accept, then execute, held while the output register is full;
//   the event (none for a bad contact) is output from the cycle after execute.
// Frame end: per ended pair, a pair-table scan visiting one entry per cycle finds the
//   next smallest pair for an end event; a scan that finds none emits frame done.
// Reset: every pair-table entry unused, output register empty, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module contact_pair_event_tracker_unit #(
  parameter int unsigned MAX_PAIRS  = cpet_pkg::MaxPairsDef,
  parameter int unsigned MAX_BODIES = cpet_pkg::MaxBodiesDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cpet_in_if.sink    item_i,
  cpet_out_if.source event_o
);
  import cpet_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cpet_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpet_datapath #(
    .MAX_PAIRS  (MAX_PAIRS),
    .MAX_BODIES (MAX_BODIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (item_i.operation),
    .first_body_i   (item_i.first_body),
    .second_body_i  (item_i.second_body),
    .out_ready_i    (event_o.ready),
    .out_valid_o    (event_o.valid),
    .event_kind_o   (event_o.event_kind),
    .event_first_o  (event_o.event_first),
    .event_second_o (event_o.event_second),
    .last_o         (event_o.last)
  );

endmodule

`default_nettype wire

### rtl/cpet_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cpet_datapath #(
  parameter int unsigned MAX_PAIRS  = cpet_pkg::MaxPairsDef,
  parameter int unsigned MAX_BODIES = cpet_pkg::MaxBodiesDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  cpet_pkg::dp_cmd_t                 cmd_i,
  output cpet_pkg::dp_sts_t                 sts_o,
  input  wire [cpet_pkg::OpW-1:0]           operation_i,
  input  wire [cpet_pkg::HandleW-1:0]       first_body_i,
  input  wire [cpet_pkg::HandleW-1:0]       second_body_i,
  input  wire                               out_ready_i,
  output logic                              out_valid_o,
  output logic [cpet_pkg::KindW-1:0]        event_kind_o,
  output logic [cpet_pkg::HandleW-1:0]      event_first_o,
  output logic [cpet_pkg::HandleW-1:0]      event_second_o,
  output logic                              last_o
);
  import cpet_pkg::*;

  localparam int unsigned IdxW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam logic [KeyW-1:0] BodyLim = KeyW'(MAX_BODIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_PAIRS - 1);

  logic [OpW-1:0]      op_q;
  logic [HandleW-1:0]  a_q, b_q;

  logic [HandleW-1:0]  lo_q [MAX_PAIRS];
  logic [HandleW-1:0]  hi_q [MAX_PAIRS];
  logic [MAX_PAIRS-1:0] active_q, active_d;
  logic [MAX_PAIRS-1:0] seen_q, seen_d;
  logic [MAX_PAIRS-1:0] pend_q, pend_d;

  logic [IdxW-1:0]     idx_q, best_idx_q;
  logic [KeyW-1:0]     best_key_q;
  logic                found_q;

  logic                out_valid_q, out_valid_d;
  logic [KindW-1:0]    kind_q;
  logic [HandleW-1:0]  first_q, second_q;
  logic                last_q;

  logic                a_ok, b_ok;
  logic [HandleW-1:0]  lo_c, hi_c;
  logic [MAX_PAIRS-1:0] used, free, free_oh, match, kill;
  logic                hit, hit_active;
  logic [KindW-1:0]    contact_kind;
  logic [KeyW-1:0]     cur_key;
  logic                cur_better;
  logic                out_load;

  assign a_ok = ({{HandleW{1'b0}}, a_q} < BodyLim) && (a_q != HandleNone);
  assign b_ok = ({{HandleW{1'b0}}, b_q} < BodyLim) && (b_q != HandleNone);
  assign lo_c = (a_q < b_q) ? a_q : b_q;
  assign hi_c = (a_q < b_q) ? b_q : a_q;

  assign used    = active_q | seen_q;
  assign free    = ~used;
  assign free_oh = free & (~free + MAX_PAIRS'(1));

  always_comb begin
    for (int i = 0; i < MAX_PAIRS; i++) begin
      match[i] = used[i] && (lo_q[i] == lo_c) && (hi_q[i] == hi_c);
      kill[i]  = used[i] && ((lo_q[i] == a_q) || (hi_q[i] == a_q));
    end
  end

  assign hit        = |match;
  assign hit_active = |(match & active_q);

  always_comb begin
    if (hit) begin
      contact_kind = hit_active ? KIND_STAY : KIND_BEGIN;
    end else if (|free) begin
      contact_kind = KIND_BEGIN;
    end else begin
      contact_kind = KIND_FULL;
    end
  end

  assign cur_key    = {lo_q[idx_q], hi_q[idx_q]};
  assign cur_better = pend_q[idx_q] && (!found_q || (cur_key < best_key_q));

  assign out_load = cmd_i.contact_wr | cmd_i.destroy_wr | cmd_i.emit_end | cmd_i.emit_done;

  always_comb begin
    active_d = active_q;
    seen_d   = seen_q;
    pend_d   = pend_q;
    if (cmd_i.contact_wr) begin
      seen_d = seen_q | (hit ? match : free_oh);
    end
    if (cmd_i.destroy_wr && a_ok) begin
      active_d = active_q & ~kill;
      seen_d   = seen_q & ~kill;
    end
    if (cmd_i.pend_init) begin
      pend_d = active_q & ~seen_q;
    end
    if (cmd_i.emit_end) begin
      pend_d[best_idx_q] = 1'b0;
    end
    if (cmd_i.emit_done) begin
      active_d = seen_q;
      seen_d   = '0;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      seen_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      active_q    <= active_d;
      seen_q      <= seen_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + IdxW'(1);
        if (cur_better) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= operation_i;
      a_q  <= first_body_i;
      b_q  <= second_body_i;
    end
    if (cmd_i.contact_wr && !hit) begin
      for (int i = 0; i < MAX_PAIRS; i++) begin
        if (free_oh[i]) begin
          lo_q[i] <= lo_c;
          hi_q[i] <= hi_c;
        end
      end
    end
    if (cmd_i.scan_step && cur_better) begin
      best_idx_q <= idx_q;
      best_key_q <= cur_key;
    end
    if (cmd_i.contact_wr) begin
      kind_q   <= contact_kind;
      first_q  <= a_q;
      second_q <= b_q;
      last_q   <= 1'b1;
    end else if (cmd_i.destroy_wr) begin
      kind_q   <= KIND_DESTROY_DONE;
      first_q  <= a_q;
      second_q <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_end) begin
      kind_q   <= KIND_END;
      first_q  <= best_key_q[KeyW-1:HandleW];
      second_q <= best_key_q[HandleW-1:0];
      last_q   <= 1'b0;
    end else if (cmd_i.emit_done) begin
      kind_q   <= KIND_FRAME_DONE;
      first_q  <= '0;
      second_q <= '0;
      last_q   <= 1'b1;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.contact_ok = a_ok && b_ok && (a_q != b_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.scan_last  = (idx_q == LastIdx);
  assign sts_o.found      = found_q;

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign event_first_o  = first_q;
  assign event_second_o = second_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

### rtl/cpet_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module cpet_controller (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  cpet_pkg::dp_sts_t sts_i,
  output cpet_pkg::dp_cmd_t cmd_o
);
  import cpet_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        unique case (sts_i.op)
          OP_CONTACT: begin
            if (!sts_i.contact_ok) begin
              state_d = StIdle;
            end else if (sts_i.out_free) begin
              cmd_o.contact_wr = 1'b1;
              state_d          = StIdle;
            end
          end
          OP_DESTROY: begin
            if (sts_i.out_free) begin
              cmd_o.destroy_wr = 1'b1;
              state_d          = StIdle;
            end
          end
          OP_FRAME_END: begin
            cmd_o.pend_init  = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          if (sts_i.found) begin
            cmd_o.emit_end   = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end else begin
            cmd_o.emit_done = 1'b1;
            state_d         = StIdle;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cpet_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cpet_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          out_valid_i,
  input wire                          out_ready_i,
  input wire [cpet_pkg::KindW-1:0]    event_kind_i,
  input wire [cpet_pkg::HandleW-1:0]  event_first_i,
  input wire [cpet_pkg::HandleW-1:0]  event_second_i,
  input wire                          last_i
);
  import cpet_pkg::*;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i)
      && $stable(event_first_i) && $stable(event_second_i) && $stable(last_i))
    else $error("stalled event changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_kind_i <= KIND_FULL)
    else $error("event kind out of range");

  a_last_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (event_kind_i != KIND_END)))
    else $error("last flag disagrees with event kind");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == KIND_FRAME_DONE |->
      event_first_i == '0 && event_second_i == '0)
    else $error("frame done carries handles");

  a_end_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == KIND_END |-> event_first_i < event_second_i)
    else $error("end pair not ordered");

endmodule

bind contact_pair_event_tracker_unit cpet_checker u_cpet_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (event_o.valid),
  .out_ready_i    (event_o.ready),
  .event_kind_i   (event_o.event_kind),
  .event_first_i  (event_o.event_first),
  .event_second_i (event_o.event_second),
  .last_i         (event_o.last)
);

`default_nettype wire
